### rtl/core/mbec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minute bucket event counter package
// Shared widths, command and register codes, and the divide-by-60 constants.
// ----------------------------------------------------------------------------
package mbec_pkg;

    // Default sizing of the counter ring.
    localparam int MAX_BUCKETS_DEF = 64;
    localparam int COUNT_WIDTH_DEF = 32;

    // Transaction field widths.
    localparam int CMD_W     = 1;
    localparam int NOW_W     = 32;
    localparam int VALUE_W   = 32;
    localparam int INDEX_W   = 6;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_COUNT_W = 7;

    localparam logic [CFG_INDEX_W-1:0] REG_START_TIME   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BUCKET_COUNT = 2'd1;
    localparam logic [CFG_COUNT_W-1:0] BUCKET_COUNT_RST = 7'd64;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_COUNT = 1'b0;
    localparam logic [CMD_W-1:0] CMD_READ  = 1'b1;

    // Minute arithmetic. A 32-bit second count gives at most 71582789 minutes.
    localparam int ELAPSED_W   = 32;
    localparam int MINUTE_W    = 27;
    // floor(d / 60) = floor(floor(d / 4) / 15), and x / 15 for a 30-bit x
    // is (x * ceil(2^34 / 15)) >> 34.
    localparam int RECIP_IN_W  = 30;
    localparam int RECIP_W     = 31;
    localparam logic [RECIP_W-1:0] RECIP_15 = 31'd1145324613;
    localparam int RECIP_SHIFT = 34;
    localparam int PROD_W      = RECIP_IN_W + RECIP_W;

endpackage

### rtl/core/mbec_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minute bucket event counter channels
// Valid/ready interfaces for the item, result and configuration channels.
// ----------------------------------------------------------------------------

// Input item: a command and the current time in seconds.
interface mbec_item_if;
    import mbec_pkg::*;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [NOW_W-1:0]   now_seconds;
    modport source (output valid, command, now_seconds, input ready);
    modport sink   (input valid, command, now_seconds, output ready);
endinterface

// Result item: the current bucket's count and ring position.
interface mbec_result_if;
    import mbec_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] bucket_value;
    logic [INDEX_W-1:0] bucket_index;
    modport source (output valid, bucket_value, bucket_index, input ready);
    modport sink   (input valid, bucket_value, bucket_index, output ready);
endinterface

// Configuration write channel.
interface mbec_cfg_if;
    import mbec_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/minute_bucket_event_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minute bucket event counter
// Ring of per-minute event counters held in one synchronous memory.
// ----------------------------------------------------------------------------
// When the minute stays within the window and the bucket count has not changed
// since the last item, an item takes the direct path: a subtract on acceptance,
// a reciprocal multiply for the divide by 60 (S_MUL), the minute and elapsed
// minutes update (S_MIN), the window check (S_EVAL), bucket clearing with the
// memory read (S_CLR), and the counter update with the memory write back and
// the result load (S_RD). When the bucket position must be computed afresh
// (after a bucket_count write, after a full window or more has passed, or when
// time moves backwards), a serial remainder unit runs in S_DIV before S_CLR;
// if a stale last bucket lies beyond a reduced bucket count, a second remainder
// pass follows. One item is in work at a time; the next is accepted while a
// result waits in the output register, and an item whose result is ready waits
// until that register frees.
// Buckets are cleared through per-entry valid bits, so there is no clearing
// pass after reset and a cleared entry reads as zero.
// ----------------------------------------------------------------------------
module minute_bucket_event_counter #(
    parameter int MAX_BUCKETS = mbec_pkg::MAX_BUCKETS_DEF,
    parameter int COUNT_WIDTH = mbec_pkg::COUNT_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mbec_item_if.sink      i_item,
    mbec_result_if.source  o_result,
    mbec_cfg_if.sink       i_cfg
);
    import mbec_pkg::*;

    localparam int IW  = $clog2(MAX_BUCKETS);
    localparam int NW  = $clog2(MAX_BUCKETS + 1);
    localparam int EW  = (NW > CFG_COUNT_W) ? NW : CFG_COUNT_W;
    localparam int DCW = $clog2(MINUTE_W);
    localparam int VW  = (COUNT_WIDTH > VALUE_W) ? COUNT_WIDTH : VALUE_W;
    localparam int XW  = (IW > INDEX_W) ? IW : INDEX_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_MIN  = 3'd2;
    localparam logic [2:0] S_EVAL = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_CLR  = 3'd5;
    localparam logic [2:0] S_RD   = 3'd6;

    // Control and datapath registers.
    logic [2:0]             r_state,  n_state;
    logic [CMD_W-1:0]       r_cmd,    n_cmd;
    logic [NOW_W-1:0]       r_diff,   n_diff;
    logic [MINUTE_W-1:0]    r_quot,   n_quot;
    logic [MINUTE_W-1:0]    r_minute, n_minute;
    logic [ELAPSED_W-1:0]   r_elapsed, n_elapsed;
    logic                   r_full,   n_full;
    logic                   r_walk,   n_walk;
    logic [IW-1:0]          r_cur,    n_cur;
    logic [IW-1:0]          r_p1,     n_p1;
    logic                   r_phase,  n_phase;
    logic [MINUTE_W-1:0]    r_dvd,    n_dvd;
    logic [NW-1:0]          r_rem,    n_rem;
    logic [DCW-1:0]         r_dcnt,   n_dcnt;
    logic [IW-1:0]          r_last_bucket;
    logic [MINUTE_W-1:0]    r_last_minute;
    logic                   r_aligned;
    logic [MAX_BUCKETS-1:0] r_valid;
    logic [NOW_W-1:0]       r_start;
    logic [CFG_COUNT_W-1:0] r_bcount;
    logic                   r_out_valid;
    logic [VALUE_W-1:0]     r_out_value;
    logic [INDEX_W-1:0]     r_out_index;

    // Counter memory and its registered read data.
    logic [COUNT_WIDTH-1:0] r_mem [MAX_BUCKETS];
    logic [COUNT_WIDTH-1:0] r_rd_data;

    logic [EW-1:0]          cfg_ext;
    logic [EW-1:0]          nb_wide;
    logic [NW-1:0]          nb;
    logic [PROD_W-1:0]      prod;
    logic [MINUTE_W-1:0]    minute_c;
    logic [NW:0]            sum_c;
    logic [NW:0]            lb1;
    logic [NW:0]            div_t;
    logic [NW:0]            div_r;
    logic [IW-1:0]          fast_cur;
    logic [IW-1:0]          near_p1;
    logic [MAX_BUCKETS-1:0] clr_mask;
    logic                   out_free;
    logic [COUNT_WIDTH-1:0] cnt_cur;
    logic [COUNT_WIDTH-1:0] cnt_new;
    logic [VW-1:0]          value_wide;
    logic [XW-1:0]          index_wide;
    logic                   load_out;
    logic                   mem_we;
    logic                   cfg_we;

    // Effective bucket count: zero counts as one, larger values saturate.
    always_comb begin
        cfg_ext = EW'(r_bcount);
        if (cfg_ext == '0) begin
            nb_wide = EW'(1);
        end else if (cfg_ext > EW'(MAX_BUCKETS)) begin
            nb_wide = EW'(MAX_BUCKETS);
        end else begin
            nb_wide = cfg_ext;
        end
        nb = nb_wide[NW-1:0];
    end

    // Arithmetic shared by the sequencer states.
    always_comb begin
        prod     = PROD_W'(r_diff[NOW_W-1:2]) * PROD_W'(RECIP_15);
        minute_c = r_quot + MINUTE_W'(1);
        sum_c    = (NW+1)'(r_last_bucket) + (NW+1)'(r_elapsed[NW-1:0]);
        if (sum_c >= (NW+1)'(nb)) begin
            sum_c = sum_c - (NW+1)'(nb);
        end
        fast_cur = sum_c[IW-1:0];
        lb1      = (NW+1)'(r_last_bucket) + (NW+1)'(1);
        near_p1  = (lb1 == (NW+1)'(nb)) ? '0 : lb1[IW-1:0];
        // One restoring remainder step per cycle.
        div_t    = {r_rem, r_dvd[MINUTE_W-1]};
        div_r    = (div_t >= (NW+1)'(nb)) ? (div_t - (NW+1)'(nb)) : div_t;
    end

    // Buckets walked over between the last bucket and the current one.
    always_comb begin
        for (int i = 0; i < MAX_BUCKETS; i++) begin
            logic [IW-1:0] idx;
            idx = IW'(i);
            if (r_p1 <= r_cur) begin
                clr_mask[i] = (idx >= r_p1) && (idx <= r_cur);
            end else begin
                clr_mask[i] = ((idx >= r_p1) && (NW'(i) < nb)) || (idx <= r_cur);
            end
        end
    end

    // Read-modify-write of the current counter.
    always_comb begin
        out_free   = !r_out_valid || o_result.ready;
        cnt_cur    = r_valid[r_cur] ? r_rd_data : '0;
        cnt_new    = (r_cmd == CMD_COUNT && cnt_cur != COUNT_MAX)
                     ? cnt_cur + COUNT_WIDTH'(1) : cnt_cur;
        value_wide = VW'(cnt_new);
        index_wide = XW'(r_cur);
        load_out   = (r_state == S_RD) && out_free;
        mem_we     = load_out && (r_cmd == CMD_COUNT);
        cfg_we     = i_cfg.valid && i_cfg.ready;
    end

    // Item sequencer.
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_diff    = r_diff;
        n_quot    = r_quot;
        n_minute  = r_minute;
        n_elapsed = r_elapsed;
        n_full    = r_full;
        n_walk    = r_walk;
        n_cur     = r_cur;
        n_p1      = r_p1;
        n_phase   = r_phase;
        n_dvd     = r_dvd;
        n_rem     = r_rem;
        n_dcnt    = r_dcnt;
        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_cmd   = i_item.command;
                    n_diff  = i_item.now_seconds - r_start;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_quot  = prod[RECIP_SHIFT +: MINUTE_W];
                n_state = S_MIN;
            end
            S_MIN: begin
                n_minute  = minute_c;
                n_elapsed = ELAPSED_W'(minute_c) - ELAPSED_W'(r_last_minute);
                n_state   = S_EVAL;
            end
            S_EVAL: begin
                n_full = (r_elapsed >= ELAPSED_W'(nb));
                if (r_aligned && !(r_elapsed >= ELAPSED_W'(nb))) begin
                    // Position follows from the last bucket and the elapsed minutes.
                    n_cur   = fast_cur;
                    n_p1    = near_p1;
                    n_walk  = (r_last_bucket != fast_cur);
                    n_state = S_CLR;
                end else begin
                    n_dvd   = r_minute;
                    n_rem   = '0;
                    n_dcnt  = '0;
                    n_phase = 1'b0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem  = div_r[NW-1:0];
                n_dvd  = {r_dvd[MINUTE_W-2:0], 1'b0};
                n_dcnt = r_dcnt + DCW'(1);
                if (r_dcnt == DCW'(MINUTE_W - 1)) begin
                    if (!r_phase) begin
                        n_cur  = div_r[IW-1:0];
                        n_walk = (r_last_bucket != div_r[IW-1:0]);
                        if (!r_full && (r_last_bucket != div_r[IW-1:0])
                            && ((NW+1)'(r_last_bucket) >= (NW+1)'(nb))) begin
                            // Stale last bucket: reduce its successor as well.
                            n_dvd   = MINUTE_W'(r_last_bucket) + MINUTE_W'(1);
                            n_rem   = '0;
                            n_dcnt  = '0;
                            n_phase = 1'b1;
                        end else begin
                            n_p1    = near_p1;
                            n_state = S_CLR;
                        end
                    end else begin
                        n_p1    = div_r[IW-1:0];
                        n_state = S_CLR;
                    end
                end
            end
            S_CLR: begin
                n_state = S_RD;
            end
            S_RD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_last_bucket <= '0;
            r_last_minute <= '0;
            r_aligned     <= 1'b1;
            r_valid       <= '0;
            r_start       <= '0;
            r_bcount      <= BUCKET_COUNT_RST;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                if (r_full) begin
                    r_valid <= '0;
                end else if (r_walk) begin
                    r_valid <= r_valid & ~clr_mask;
                end
                r_last_bucket <= r_cur;
                r_last_minute <= r_minute;
            end
            // A new bucket count invalidates the quick position update.
            if (cfg_we && (i_cfg.index == REG_BUCKET_COUNT)) begin
                r_aligned <= 1'b0;
            end else if (r_state == S_CLR) begin
                r_aligned <= 1'b1;
            end
            if (mem_we) begin
                r_valid[r_cur] <= 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_we) begin
                case (i_cfg.index)
                    REG_START_TIME: begin
                        r_start <= i_cfg.data[NOW_W-1:0];
                    end
                    REG_BUCKET_COUNT: begin
                        r_bcount <= i_cfg.data[CFG_COUNT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_diff    <= n_diff;
        r_quot    <= n_quot;
        r_minute  <= n_minute;
        r_elapsed <= n_elapsed;
        r_full    <= n_full;
        r_walk    <= n_walk;
        r_cur     <= n_cur;
        r_p1      <= n_p1;
        r_phase   <= n_phase;
        r_dvd     <= n_dvd;
        r_rem     <= n_rem;
        r_dcnt    <= n_dcnt;
        if (load_out) begin
            r_out_value <= value_wide[VALUE_W-1:0];
            r_out_index <= index_wide[INDEX_W-1:0];
        end
    end

    // Counter memory: read while clearing, written back for a count once the result is loaded in S_RD.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLR) begin
            r_rd_data <= r_mem[r_cur];
        end
        if (mem_we) begin
            r_mem[r_cur] <= cnt_new;
        end
    end

    // Channel outputs.
    assign i_item.ready          = (r_state == S_IDLE);
    assign i_cfg.ready           = 1'b1;
    assign o_result.valid        = r_out_valid;
    assign o_result.bucket_value = r_out_value;
    assign o_result.bucket_index = r_out_index;

    // The bucket read from memory always lies inside the ring in use.
    a_cur_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> (NW'(r_cur) < nb))
        else $error("current bucket outside the ring");

    // The remainder unit keeps its partial remainder below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < nb))
        else $error("partial remainder not below bucket count");

    // An aligned last bucket is a valid ring position.
    a_aligned_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_aligned |-> (NW'(r_last_bucket) < nb))
        else $error("aligned last bucket outside the ring");

    // A counted event leaves its bucket marked as holding data.
    a_count_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> r_valid[$past(r_cur)])
        else $error("counted bucket not marked valid");

    // A result is loaded only after the memory read of the same item.
    a_load_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && $past(r_state) != S_RD) |-> ($past(r_state) == S_CLR))
        else $error("result loaded without a memory read");

endmodule

### bench/tb_minute_bucket_event_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minute bucket event counter testbench
// Drives count and read transactions through several register settings and
// idle patterns. A scoreboard keeps its own copy of the minute ring, predicts
// each bucket report, and compares it field by field with the block output.
// ----------------------------------------------------------------------------
module tb_minute_bucket_event_counter;
    import mbec_pkg::*;

    localparam int                     RUN_LIMIT   = 1000000;
    localparam int                     DRAIN_WAIT  = 80;
    localparam int                     RANDOM_ITEMS = 194;
    localparam int                     PHASE_COUNT = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE   = 2'd2;
    localparam logic [31:0]            SEC_PER_MIN = 32'd60;

    // One bucket report as the block returns it.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
    } t_bucket_report;

    // Register setting and idle pattern of one test phase.
    typedef struct {
        logic [CFG_DATA_W-1:0]  start_sec;
        logic [CFG_COUNT_W-1:0] ring_reg;
        int                     send_pct;
        int                     stall_pct;
    } t_phase_cfg;

    // Scoreboard with its own model of the minute ring.
    class t_ring_scoreboard;
        logic [VALUE_W-1:0]     minute_count[MAX_BUCKETS_DEF];
        logic [INDEX_W-1:0]     last_pos;
        logic [31:0]            last_min;
        logic [CFG_DATA_W-1:0]  start_sec;
        logic [CFG_COUNT_W-1:0] ring_reg;
        t_bucket_report         expected_buckets[$];
        int                     errors;

        function new();
            foreach (minute_count[i]) minute_count[i] = '0;
            last_pos  = '0;
            last_min  = '0;
            start_sec = '0;
            ring_reg  = BUCKET_COUNT_RST;
            errors    = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_START_TIME) begin
                start_sec = data;
            end else if (idx == REG_BUCKET_COUNT) begin
                ring_reg = data[CFG_COUNT_W-1:0];
            end
        endfunction

        // Buckets actually in use: zero means one, anything above the ring size saturates.
        function int unsigned ring_len();
            int unsigned n;
            n = ring_reg;
            if (n == 0) n = 1;
            if (n > MAX_BUCKETS_DEF) n = MAX_BUCKETS_DEF;
            return n;
        endfunction

        function int pending();
            return expected_buckets.size();
        endfunction

        // Advance the ring to the minute of an accepted transaction and queue its report.
        function void accept_event(logic [CMD_W-1:0] cmd, logic [NOW_W-1:0] now);
            int unsigned    n;
            int unsigned    cur;
            int unsigned    pos;
            int unsigned    steps;
            logic [31:0]    diff;
            logic [32:0]    shifted;
            logic [31:0]    minute;
            logic [31:0]    gap;
            t_bucket_report rep;
            n       = ring_len();
            diff    = now - start_sec;
            shifted = {1'b0, diff} + 33'd60;
            minute  = 32'(shifted / 33'd60);
            cur     = minute % n;
            gap     = minute - last_min;
            // A full window or more wipes the whole ring; otherwise clear the skipped buckets.
            if (gap >= n) begin
                foreach (minute_count[i]) minute_count[i] = '0;
            end else begin
                pos   = last_pos;
                steps = 0;
                while (pos != cur && steps <= n) begin
                    pos = (pos + 1) % n;
                    minute_count[pos] = '0;
                    steps++;
                end
            end
            last_pos = INDEX_W'(cur);
            last_min = minute;
            if (cmd == CMD_COUNT && minute_count[cur] != '1) begin
                minute_count[cur] = minute_count[cur] + 1'b1;
            end
            rep.value = minute_count[cur];
            rep.index = INDEX_W'(cur);
            expected_buckets.push_back(rep);
        endfunction

        // Compare one result transaction with the oldest expected report.
        function void check_report(logic [VALUE_W-1:0] value, logic [INDEX_W-1:0] index);
            t_bucket_report exp_rep;
            if (expected_buckets.size() == 0) begin
                $display("%0t: unexpected result value=%0d index=%0d", $time, value, index);
                errors++;
                return;
            end
            exp_rep = expected_buckets.pop_front();
            if (exp_rep.value !== value) begin
                $display("%0t: bucket_value mismatch: expected %0d, actual %0d",
                         $time, exp_rep.value, value);
                errors++;
            end
            if (exp_rep.index !== index) begin
                $display("%0t: bucket_index mismatch: expected %0d, actual %0d",
                         $time, exp_rep.index, index);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    mbec_item_if   item_ch ();
    mbec_result_if result_ch ();
    mbec_cfg_if    cfg_ch ();

    minute_bucket_event_counter dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    t_ring_scoreboard sb = new();

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          cycle_count = 0;
    logic [31:0] now_sec;

    // Free-running clock.
    always #10 clk = ~clk;

    // Receiver: random back-pressure at the rate of the current phase.
    always @(posedge clk) begin
        result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor: every accepted transaction on each channel goes to the scoreboard.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                sb.write_register(cfg_ch.index, cfg_ch.data);
            end
            if (item_ch.valid && item_ch.ready) begin
                sb.accept_event(item_ch.command, item_ch.now_seconds);
            end
            if (result_ch.valid && result_ch.ready) begin
                sb.check_report(result_ch.bucket_value, result_ch.bucket_index);
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("%0t: timeout with %0d reports outstanding", $time, sb.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Present one item after a random idle gap; valid stays high after acceptance.
    task automatic send_item(logic [CMD_W-1:0] cmd, logic [NOW_W-1:0] now);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.command     <= cmd;
        item_ch.now_seconds <= now;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stop sending and wait until every expected report has come back.
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Next time stamp: mostly a forward walk in small steps, with minute skips,
    // full-window jumps, backward steps, times before the start, and noise.
    task automatic step_time();
        int unsigned n;
        int unsigned sel;
        n   = sb.ring_len();
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
            now_sec = now_sec + $urandom_range(0, 40);
        end else if (sel < 75) begin
            now_sec = now_sec + SEC_PER_MIN * $urandom_range(1, n) + $urandom_range(0, 59);
        end else if (sel < 82) begin
            now_sec = now_sec + SEC_PER_MIN * $urandom_range(n, 4 * n) + $urandom_range(0, 59);
        end else if (sel < 88) begin
            now_sec = now_sec - $urandom_range(1, 900);
        end else if (sel < 94) begin
            now_sec = sb.start_sec - $urandom_range(1, 4000);
        end else begin
            now_sec = $urandom();
        end
    endtask

    t_phase_cfg phases[PHASE_COUNT];
    logic [CFG_DATA_W-1:0] reg_data;

    initial begin
        // Register settings and idle patterns, extremes included.
        phases[0] = '{32'd0,        7'd64,                  0,  0};
        phases[1] = '{$urandom(),   7'd5,                   75, 0};
        phases[2] = '{32'hFFFFFFFF, 7'd1,                   0,  75};
        phases[3] = '{$urandom(),   7'd0,                   29, 29};
        phases[4] = '{32'd0,        7'd127,                 0,  0};
        phases[5] = '{$urandom(),   7'd2,                   75, 0};
        phases[6] = '{$urandom(),   7'd64,                  0,  75};
        phases[7] = '{$urandom(),   7'($urandom_range(3, 63)), 29, 29};

        rst_n               <= 1'b0;
        item_ch.valid       <= 1'b0;
        item_ch.command     <= CMD_COUNT;
        item_ch.now_seconds <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= REG_START_TIME;
        cfg_ch.data         <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items under the reset settings: same minute, next minute,
        // skipped buckets, wrap of the ring, exactly a full window, latest time,
        // time moving backwards, and alternating bit patterns.
        send_item(CMD_COUNT, 32'd0);
        send_item(CMD_COUNT, 32'd59);
        send_item(CMD_READ,  32'd30);
        send_item(CMD_COUNT, 32'd60);
        send_item(CMD_COUNT, 32'd300);
        send_item(CMD_READ,  32'd3780);
        send_item(CMD_COUNT, 32'd7560);
        send_item(CMD_COUNT, 32'd11400);
        send_item(CMD_COUNT, 32'hFFFFFFFF);
        send_item(CMD_READ,  32'hFFFFFFFF);
        send_item(CMD_COUNT, 32'd0);
        send_item(CMD_COUNT, 32'hAAAAAAAA);
        send_item(CMD_READ,  32'h55555555);
        drain();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            // Registers change only while the block holds no work.
            send_idle_pct  = phases[p].send_pct;
            recv_stall_pct = phases[p].stall_pct;
            if (p == 1) begin
                write_reg(REG_SPARE, $urandom());
            end
            write_reg(REG_START_TIME, phases[p].start_sec);
            reg_data = $urandom();
            reg_data[CFG_COUNT_W-1:0] = phases[p].ring_reg;
            write_reg(REG_BUCKET_COUNT, reg_data);

            // The first item sits just before the start time, so the difference wraps.
            send_item(CMD_COUNT, phases[p].start_sec - 32'd1);
            now_sec = phases[p].start_sec + $urandom_range(0, 100000);
            for (int k = 0; k < RANDOM_ITEMS; k++) begin
                step_time();
                send_item(($urandom_range(0, 3) == 0) ? CMD_READ : CMD_COUNT, now_sec);
            end
            drain();
        end

        // Let any stray result show up before the verdict.
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/mbec_pkg.sv
rtl/core/mbec_if.sv
rtl/core/minute_bucket_event_counter.sv
bench/tb_minute_bucket_event_counter.sv
